// ===== rtl/core/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AST_CLK(lbl, prop, msg)
`define AST_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/core/mtd_pkg.sv =====
`timescale 1ns / 1ps
package mtd_pkg;
  localparam int SLOTS = 512;
  localparam int FIRE_LIMIT = 8;
  localparam int SW = $clog2(SLOTS);
  localparam int PW = SW + 1;
  localparam int CW = $clog2(FIRE_LIMIT + 1);
  localparam int FW = (FIRE_LIMIT > 1) ? $clog2(FIRE_LIMIT) : 1;

  localparam logic [1:0] MODE_REG   = 2'd0;
  localparam logic [1:0] MODE_DEREG = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] CFG_TICK_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MIN_TICK      = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE      = 2'd2;
  localparam logic [1:0] CFG_MAX_FIRES     = 2'd3;

  typedef struct packed {
    logic        active;
    logic        periodic;
    logic [31:0] interval;
    logic [31:0] arm;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic reg_scan;
    logic fire_scan;
    logic next_scan;
    logic to_next;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic reg_done;
    logic fire_done;
    logic next_done;
    logic out_last;
  } sts_t;
endpackage

// ===== rtl/core/mtd_ctrl.sv =====
`timescale 1ns / 1ps
module mtd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_mode,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mtd_pkg::sts_t sts,
  output mtd_pkg::cmd_t cmd
);
  import mtd_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_REG   = 3'd2;
  localparam logic [2:0] S_FIRE  = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    cmd           = '0;
    cmd.clear     = (state_r == S_CLEAR);
    cmd.load      = acc;
    cmd.reg_scan  = (state_r == S_REG);
    cmd.fire_scan = (state_r == S_FIRE);
    cmd.next_scan = (state_r == S_NEXT);
    cmd.to_next   = (state_r == S_FIRE) && sts.fire_done;
    cmd.emit      = out_tvalid && out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            MODE_REG:  state_nxt = S_REG;
            MODE_TICK: state_nxt = S_FIRE;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_REG:  if (sts.reg_done) state_nxt = S_OUT;
      S_FIRE: if (sts.fire_done) state_nxt = S_NEXT;
      S_NEXT: if (sts.next_done) state_nxt = S_OUT;
      S_OUT:  if (cmd.emit && sts.out_last) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end
endmodule

// ===== rtl/core/mtd_dp.sv =====
`timescale 1ns / 1ps
module mtd_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  mtd_pkg::cmd_t cmd,
  output mtd_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    in_mode,
  input  logic [31:0]   in_now,
  input  logic [31:0]   in_interval,
  input  logic          in_periodic,
  input  logic [8:0]    in_timer_index,
  input  logic [31:0]   in_period,
  output logic          o_status,
  output logic [8:0]    o_slot,
  output logic          o_fired,
  output logic          o_last,
  output logic [15:0]   o_next_tick,
  output logic          o_on_time,
  output logic          o_in_period
);
  import mtd_pkg::*;

  entry_t slot_mem_r [SLOTS];
  entry_t rd_q_r, wd;
  logic          we, rd_en;
  logic [SW-1:0] wa;

  logic [15:0] tick_int_r, min_tick_r, debounce_r;
  logic [3:0]  max_fires_r;

  logic [1:0]  it_mode_r;
  logic [31:0] it_now_r, it_int_r;
  logic        it_per_r;

  logic [PW-1:0] ptr_r;
  logic          rd_vld_r;
  logic [SW-1:0] idx_r;
  logic [SW-1:0] scan_start_r;
  logic          on_time_r;
  logic [31:0]   last_tick_r, late_r;
  logic [15:0]   d_r;
  logic          res_status_r, res_inp_r;
  logic [SW-1:0] res_slot_r;
  logic [CW-1:0] cnt_r, em_r, lim;
  logic [SW-1:0] fbuf_r [FIRE_LIMIT];

  logic [31:0] el, rem, gap, since;
  logic        expired, scan_end, fire_hit, is_tick;

  assign el       = it_now_r - rd_q_r.arm;
  assign expired  = rd_q_r.active && (el >= rd_q_r.interval);
  assign rem      = rd_q_r.interval - el;
  assign scan_end = !rd_vld_r && (ptr_r == PW'(SLOTS));
  assign fire_hit = cmd.fire_scan && rd_vld_r && expired;
  assign gap      = in_now - last_tick_r;
  assign since    = in_now - late_r;
  assign rd_en    = (cmd.reg_scan || cmd.fire_scan || cmd.next_scan) && (ptr_r < PW'(SLOTS));

  always_comb begin
    if (max_fires_r == 4'd0)                    lim = CW'(1);
    else if (32'(max_fires_r) > FIRE_LIMIT)     lim = CW'(FIRE_LIMIT);
    else                                        lim = CW'(max_fires_r);
  end

  always_comb begin
    sts            = '0;
    sts.clear_done = cmd.clear && (ptr_r == PW'(SLOTS - 1));
    sts.reg_done   = cmd.reg_scan && ((rd_vld_r && !rd_q_r.active) || scan_end);
    sts.fire_done  = (fire_hit && ((cnt_r + CW'(1)) >= lim)) || (cmd.fire_scan && scan_end);
    sts.next_done  = cmd.next_scan && ((rd_vld_r && expired) || scan_end);
    sts.out_last   = o_last;
  end

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = rd_q_r;
    if (cmd.clear) begin
      we = 1'b1;
      wa = ptr_r[SW-1:0];
      wd = '0;
    end else if (cmd.load && in_mode == MODE_DEREG && 32'(in_timer_index) < SLOTS) begin
      we = 1'b1;
      wa = in_timer_index[SW-1:0];
      wd = '0;
    end else if (cmd.reg_scan && rd_vld_r && !rd_q_r.active) begin
      we = 1'b1;
      wd = '{active: 1'b1, periodic: it_per_r, interval: it_int_r, arm: it_now_r};
    end else if (fire_hit) begin
      we = 1'b1;
      if (rd_q_r.periodic) wd.arm = it_now_r;
      else                 wd.active = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) slot_mem_r[wa] <= wd;
    if (rd_en) rd_q_r <= slot_mem_r[ptr_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode_r <= in_mode;
      it_now_r  <= in_now;
      it_int_r  <= in_interval;
      it_per_r  <= in_periodic;
    end
    if (fire_hit) fbuf_r[cnt_r[FW-1:0]] <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_int_r   <= 16'd100;
      min_tick_r   <= 16'd25;
      debounce_r   <= 16'd1000;
      max_fires_r  <= 4'd8;
      ptr_r        <= '0;
      rd_vld_r     <= 1'b0;
      idx_r        <= '0;
      scan_start_r <= '0;
      on_time_r    <= 1'b1;
      last_tick_r  <= '0;
      late_r       <= '0;
      cnt_r        <= '0;
      em_r         <= '0;
      d_r          <= '0;
      res_status_r <= 1'b0;
      res_inp_r    <= 1'b0;
      res_slot_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TICK_INTERVAL: tick_int_r  <= cfg_data;
          CFG_MIN_TICK:      min_tick_r  <= cfg_data;
          CFG_DEBOUNCE:      debounce_r  <= cfg_data;
          CFG_MAX_FIRES:     max_fires_r <= cfg_data[3:0];
          default:           ;
        endcase
      end

      if (cmd.load || cmd.to_next) begin
        ptr_r    <= (cmd.load && in_mode == MODE_TICK) ? {1'b0, scan_start_r} : '0;
        rd_vld_r <= 1'b0;
      end else if (rd_en) begin
        ptr_r    <= ptr_r + PW'(1);
        idx_r    <= ptr_r[SW-1:0];
        rd_vld_r <= 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
        if (cmd.clear) ptr_r <= (ptr_r == PW'(SLOTS - 1)) ? '0 : ptr_r + PW'(1);
      end

      if (cmd.reg_scan) begin
        if (rd_vld_r && !rd_q_r.active) begin
          res_slot_r <= idx_r;
        end else if (scan_end) begin
          res_status_r <= 1'b1;
        end
      end

      if (fire_hit) begin
        cnt_r <= cnt_r + CW'(1);
        if ((cnt_r + CW'(1)) >= lim) scan_start_r <= idx_r;
      end else if (cmd.fire_scan && scan_end) begin
        scan_start_r <= '0;
      end

      if (cmd.next_scan && rd_vld_r && rd_q_r.active) begin
        if (!expired) begin
          if (rem < 32'(d_r)) d_r <= rem[15:0];
        end else begin
          d_r <= min_tick_r;
        end
      end

      if (cmd.to_next) d_r <= tick_int_r;

      if (cmd.emit) em_r <= em_r + CW'(1);

      if (cmd.load) begin
        res_status_r <= 1'b0;
        res_slot_r   <= '0;
        res_inp_r    <= (in_mode == MODE_QUERY) && (since > in_period);
        cnt_r        <= '0;
        em_r         <= '0;
        if (in_mode == MODE_TICK) begin
          last_tick_r <= in_now;
          if (gap >= {15'd0, tick_int_r, 1'b0}) begin
            on_time_r <= 1'b0;
            late_r    <= in_now;
          end else if (!on_time_r && since > 32'(debounce_r)) begin
            on_time_r <= 1'b1;
          end
        end
      end
    end
  end

  assign is_tick     = (it_mode_r == MODE_TICK);
  assign o_status    = res_status_r;
  assign o_on_time   = on_time_r;
  assign o_in_period = res_inp_r;
  assign o_fired     = is_tick && (cnt_r != '0);
  assign o_last      = !is_tick || (cnt_r == '0) || ((em_r + CW'(1)) == cnt_r);
  assign o_next_tick = !is_tick ? 16'd0 : ((d_r < min_tick_r) ? min_tick_r : d_r);
  assign o_slot      = !is_tick ? 9'(res_slot_r) :
                       ((cnt_r == '0) ? 9'd0 : 9'(fbuf_r[em_r[FW-1:0]]));
endmodule

// ===== rtl/core/multi_timer_table_dispatcher_top.sv =====
// Operation: register runs a free-slot scan; deregister and query answer without a scan;
//   tick runs a fire scan plus a next-delay scan, one slot per cycle.
// Throughput: one item at a time; results leave one per cycle when taken.
// Reset: synchronous, active low; then a pass over all 512 slots clears the slot table
//   before the first item is taken (config writes accepted throughout).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_timer_table_dispatcher_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_ms[31:0], interval_ms[63:32], periodic[64], timer_index[73:65], period_ms[105:74]
  input  logic [111:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[0], slot[9:1], next_tick_ms[25:10], on_time[26], in_period[27]
  output logic [31:0]  out_tdata,
  // fired[0]
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import mtd_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        o_status, o_on_time, o_in_period;
  logic [8:0]  o_slot;
  logic [15:0] o_next_tick;

  assign cfg_ready = 1'b1;

  mtd_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_mode(in_tuser),
    .out_tvalid, .out_tready, .sts, .cmd
  );

  mtd_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_mode(in_tuser),
    .in_now(in_tdata[31:0]),
    .in_interval(in_tdata[63:32]),
    .in_periodic(in_tdata[64]),
    .in_timer_index(in_tdata[73:65]),
    .in_period(in_tdata[105:74]),
    .o_status, .o_slot, .o_fired(out_tuser), .o_last(out_tlast),
    .o_next_tick, .o_on_time, .o_in_period
  );

  assign out_tdata = {4'd0, o_in_period, o_on_time, o_next_tick, o_slot, o_status};

  `AST_NEVER(a_one_at_a_time, in_tready && out_tvalid, "input taken while result pending")
  `AST_CLK(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "ready after accept")
  `AST_CLK(a_done_after_last, out_tvalid && out_tready && out_tlast |=> !out_tvalid,
           "result after last")
  `AST_CLK(a_full_only_ok_slot, out_tvalid && out_tdata[0] |-> out_tdata[9:1] == 9'd0,
           "full status with slot")
endmodule
